FILE: design/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// Shared widths, constants, codes and control structs of the dual tilt monitor.
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int CAL_SAMPLES  = 100;
  localparam int CNT_W        = 10;
  localparam int SUM_W        = 20;
  localparam int OFFS_W       = 14;
  localparam int RAW_W        = 12;
  localparam int V_W          = 15;
  localparam int ANGLE_W      = 16;
  localparam int ANGLE_LIMIT  = 23040;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;
  localparam int ALPHA_W      = 16;
  localparam int THR_W        = 15;
  localparam int ONE_G_W      = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int ATAN_W       = 23;

  // reciprocal of CAL_SAMPLES, exact floor for any 20 bit magnitude
  localparam int AVG_SHIFT    = 30;
  localparam int AVG_W        = 31;
  localparam int AVG_RECIP    = (2 ** AVG_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES;

  typedef logic signed [RAW_W-1:0]   raw_t;
  typedef logic signed [OFFS_W-1:0]  offs_t;
  typedef logic signed [V_W-1:0]     axis_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_ONE_G  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL, ST_DIV, ST_OFFS, ST_VSUB, ST_SQR, ST_SUM, ST_ROOT,
    ST_INIT, ST_ROT, ST_RND, ST_MUL, ST_FILT, ST_DONE
  } state_t;

  typedef struct packed {
    logic       sqr;
    logic       sum;
    logic       root;
    logic       init;
    logic       rot;
    logic       rnd;
    logic       mul;
    logic       filt;
    logic [3:0] step;
  } lane_ctl_t;

  typedef struct packed {
    logic acc;
    logic div;
    logic offs;
  } cal_ctl_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [3:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      4'd0:    r = 23'd2949120;
      4'd1:    r = 23'd1740967;
      4'd2:    r = 23'd919879;
      4'd3:    r = 23'd466945;
      4'd4:    r = 23'd234379;
      4'd5:    r = 23'd117304;
      4'd6:    r = 23'd58666;
      4'd7:    r = 23'd29335;
      4'd8:    r = 23'd14668;
      4'd9:    r = 23'd7334;
      4'd10:   r = 23'd3667;
      4'd11:   r = 23'd1833;
      4'd12:   r = 23'd917;
      4'd13:   r = 23'd458;
      4'd14:   r = 23'd229;
      4'd15:   r = 23'd115;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/dat_in_if.sv
// ----------------------------------------------------------------------------
// dat_in_if
// Sample channel: mode bit and one 3-axis sample from each sensor.
// ----------------------------------------------------------------------------
interface dat_in_if;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [12-1:0]    accel1_x;
  logic signed [12-1:0]    accel1_y;
  logic signed [12-1:0]    accel1_z;
  logic signed [12-1:0]    accel2_x;
  logic signed [12-1:0]    accel2_y;
  logic signed [12-1:0]    accel2_z;

  modport source (output valid, mode, accel1_x, accel1_y, accel1_z,
                  accel2_x, accel2_y, accel2_z, input ready);
  modport sink   (input valid, mode, accel1_x, accel1_y, accel1_z,
                  accel2_x, accel2_y, accel2_z, output ready);
endinterface

FILE: design/dat_out_if.sv
// ----------------------------------------------------------------------------
// dat_out_if
// Result channel: four filtered angles, lamp and calibration flag.
// ----------------------------------------------------------------------------
interface dat_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   roll_one;
  logic signed [15:0]   pitch_one;
  logic signed [15:0]   roll_two;
  logic signed [15:0]   pitch_two;
  logic                 lamp_on;
  logic                 cal_complete;

  modport source (output valid, roll_one, pitch_one, roll_two, pitch_two,
                  lamp_on, cal_complete, input ready);
  modport sink   (input valid, roll_one, pitch_one, roll_two, pitch_two,
                  lamp_on, cal_complete, output ready);
endinterface

FILE: design/dat_cal.sv
// ----------------------------------------------------------------------------
// dat_cal
// Calibration sums, sample count, reciprocal averaging and axis offsets.
// ----------------------------------------------------------------------------
module dat_cal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dat_pkg::cal_ctl_t             ctl,
  input  dat_pkg::raw_t                 raw [6],
  input  logic [dat_pkg::ONE_G_W-1:0]   one_g,
  output logic                          hit,
  output dat_pkg::offs_t                offs [6]
);
  import dat_pkg::*;

  logic signed [SUM_W-1:0] sum_r   [6];
  logic signed [SUM_W-1:0] sum_nxt [6];
  logic [SUM_W-1:0]        quo_r   [6];
  logic [SUM_W-1:0]        quo_nxt [6];
  logic                    neg_r   [6];
  logic                    neg_nxt [6];
  offs_t                   offs_r  [6];
  offs_t                   offs_nxt[6];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        count_inc;

  assign count_inc = count_r + CNT_W'(1);
  assign hit       = count_inc >= CNT_W'(CAL_SAMPLES);

  always_comb begin
    logic signed [SUM_W:0]         s;
    logic signed [SUM_W-1:0]       sat;
    logic [SUM_W+AVG_W-1:0]        prod;
    logic signed [SUM_W:0]         avg;
    count_nxt = count_r;
    for (int i = 0; i < 6; i++) begin
      sum_nxt[i]  = sum_r[i];
      quo_nxt[i]  = quo_r[i];
      neg_nxt[i]  = neg_r[i];
      offs_nxt[i] = offs_r[i];
      s   = {sum_r[i][SUM_W-1], sum_r[i]} + (SUM_W+1)'(raw[i]);
      if (s > (SUM_W+1)'(2 ** (SUM_W-1) - 1)) begin
        sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (s < -(SUM_W+1)'(2 ** (SUM_W-1))) begin
        sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sat = s[SUM_W-1:0];
      end
      prod = (SUM_W+AVG_W)'(quo_r[i]) * (SUM_W+AVG_W)'(AVG_RECIP);
      avg = neg_r[i] ? -$signed({1'b0, quo_r[i]}) : $signed({1'b0, quo_r[i]});
      if (i == 2 || i == 5) begin
        avg = avg - $signed((SUM_W+1)'(one_g));
      end
      if (ctl.acc) begin
        sum_nxt[i] = sat;
        if (hit) begin
          neg_nxt[i] = sat[SUM_W-1];
          quo_nxt[i] = sat[SUM_W-1] ? SUM_W'(-sat) : SUM_W'(sat);
        end
      end
      // magnitude over CAL_SAMPLES, truncated toward zero with the sign
      if (ctl.div) begin
        quo_nxt[i] = SUM_W'(prod >> AVG_SHIFT);
      end
      if (ctl.offs) begin
        offs_nxt[i] = avg[OFFS_W-1:0];
        sum_nxt[i]  = '0;
      end
    end
    if (ctl.acc) begin
      count_nxt = hit ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 6; i++) begin
        sum_r[i]  <= '0;
        offs_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < 6; i++) begin
        sum_r[i]  <= sum_nxt[i];
        offs_r[i] <= offs_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      quo_r[i] <= quo_nxt[i];
      neg_r[i] <= neg_nxt[i];
    end
  end

  assign offs = offs_r;

endmodule

FILE: design/dat_lane.sv
// ----------------------------------------------------------------------------
// dat_lane
// One angle lane: integer square root, CORDIC vectoring, rounding, filter.
// ----------------------------------------------------------------------------
module dat_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dat_pkg::lane_ctl_t            ctl,
  input  dat_pkg::axis_t                num,
  input  dat_pkg::axis_t                a,
  input  dat_pkg::axis_t                b,
  input  logic [dat_pkg::ALPHA_W-1:0]   alpha,
  output dat_pkg::angle_t               filt
);
  import dat_pkg::*;

  localparam int SQ_W = 2 * V_W;
  localparam int XY_W = 34;
  localparam int Z_W  = 25;

  logic [SQ_W-1:0]        sqa_r, sqa_nxt, sqb_r, sqb_nxt;
  logic [31:0]            rem_r, rem_nxt, res_r, res_nxt;
  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  angle_t                 ang_r, ang_nxt;
  logic signed [33:0]     prod_r, prod_nxt;
  angle_t                 f_r, f_nxt;

  always_comb begin
    logic [SQ_W-1:0]        pa, pb;
    logic [31:0]            bitv, trial;
    logic [15:0]            mag;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  at, zr, q;
    logic signed [16:0]     d;
    logic signed [34:0]     pr;
    logic signed [34:0]     delta;
    sqa_nxt  = sqa_r;
    sqb_nxt  = sqb_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    ang_nxt  = ang_r;
    prod_nxt = prod_r;
    f_nxt    = f_r;
    pa       = SQ_W'(a * a);
    pb       = SQ_W'(b * b);
    bitv     = 32'h4000_0000 >> {ctl.step, 1'b0};
    trial    = res_r + bitv;
    mag      = res_r[15:0];
    dx       = y_r >>> ctl.step;
    dy       = x_r >>> ctl.step;
    at       = $signed({2'b00, atan_q16(ctl.step)});
    zr       = z_r + Z_W'(128);
    q        = zr >>> 8;
    d        = {ang_r[ANGLE_W-1], ang_r} - {f_r[ANGLE_W-1], f_r};
    pr       = {prod_r[33], prod_r} + 35'sd32768;
    delta    = pr >>> 16;
    if (ctl.sqr) begin
      sqa_nxt = pa;
      sqb_nxt = pb;
    end
    if (ctl.sum) begin
      rem_nxt = 32'(sqa_r) + 32'(sqb_r);
      res_nxt = '0;
    end
    if (ctl.root) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bitv;
      end else begin
        res_nxt = res_r >> 1;
      end
    end
    if (ctl.init) begin
      x_nxt = $signed({2'b00, mag, 16'h0000});
      y_nxt = $signed({{3{num[V_W-1]}}, num, 16'h0000});
      z_nxt = '0;
    end
    if (ctl.rot) begin
      if (!y_r[XY_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
    end
    if (ctl.rnd) begin
      if (num == '0) begin
        ang_nxt = '0;
      end else if (mag == '0) begin
        ang_nxt = num[V_W-1] ? -ANGLE_W'(ANGLE_LIMIT) : ANGLE_W'(ANGLE_LIMIT);
      end else if (q > Z_W'(ANGLE_LIMIT)) begin
        ang_nxt = ANGLE_W'(ANGLE_LIMIT);
      end else if (q < -Z_W'(ANGLE_LIMIT)) begin
        ang_nxt = -ANGLE_W'(ANGLE_LIMIT);
      end else begin
        ang_nxt = q[ANGLE_W-1:0];
      end
    end
    if (ctl.mul) begin
      prod_nxt = $signed({1'b0, alpha}) * d;
    end
    if (ctl.filt) begin
      f_nxt = f_r + delta[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sqa_r  <= sqa_nxt;
    sqb_r  <= sqb_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    ang_r  <= ang_nxt;
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= '0;
    end else begin
      f_r <= f_nxt;
    end
  end

  assign filt = f_r;

endmodule

FILE: design/dat_merge.sv
// ----------------------------------------------------------------------------
// dat_merge
// Combines the four lane angles into the lamp decision and the result register.
// ----------------------------------------------------------------------------
module dat_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  dat_pkg::angle_t             ang [4],
  input  logic [dat_pkg::THR_W-1:0]   thresh,
  input  logic                        cal_done,
  output logic                        free,
  dat_out_if.source                   out_ch
);
  import dat_pkg::*;

  logic   valid_r, valid_nxt;
  angle_t ang_r [4];
  logic   lamp_r, done_r;
  logic   lamp;

  always_comb begin
    logic [ANGLE_W:0] m;
    lamp = 1'b0;
    for (int i = 0; i < 4; i++) begin
      m = ang[i][ANGLE_W-1] ? (ANGLE_W+1)'(-{ang[i][ANGLE_W-1], ang[i]})
                            : (ANGLE_W+1)'({ang[i][ANGLE_W-1], ang[i]});
      if (m > (ANGLE_W+1)'(thresh)) begin
        lamp = 1'b1;
      end
    end
  end

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        ang_r[i] <= ang[i];
      end
      lamp_r <= lamp;
      done_r <= cal_done;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.roll_one     = ang_r[0];
  assign out_ch.pitch_one    = ang_r[1];
  assign out_ch.roll_two     = ang_r[2];
  assign out_ch.pitch_two    = ang_r[3];
  assign out_ch.lamp_on      = lamp_r;
  assign out_ch.cal_complete = done_r;

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || out_ch.ready))
    else $error("result overwritten while stalled");

endmodule

FILE: design/dual_accel_tilt_monitor.sv
// ----------------------------------------------------------------------------
// dual_accel_tilt_monitor
// Roll and pitch of two accelerometers with offset calibration, smoothing
// and a tilt lamp.
// ----------------------------------------------------------------------------
//  port      dir   handshake      carries
//  in_ch     in    valid/ready    mode, accel1_x/y/z, accel2_x/y/z
//  out_ch    out   valid/ready    roll/pitch one and two, lamp_on, cal_complete
//  cfg_*     in    write enable   filter_alpha, tilt_threshold, one_g_counts
//
// for a measure item, from accept to result, four lanes run a
// 16-step square root and then a 16-step CORDIC
// a calibration item adds to the sums; when it closes the run it adds a
// reciprocal divide and an offset update; one item is worked on at a time
// the next item is taken while a result still waits in the output register
// reset is synchronous and clears offsets, sums, count and filters
module dual_accel_tilt_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  dat_in_if.sink                           in_ch,
  dat_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dat_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dat_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [THR_W-1:0]    thresh_r;
  logic [ONE_G_W-1:0]  one_g_r;
  logic                mode_r;
  raw_t                raw_r [6];
  axis_t               v_r   [6];
  offs_t               offs  [6];
  angle_t              ang   [4];
  logic                done_r, done_nxt;
  logic                hit;
  logic                free;
  logic                load;
  logic                accept;
  lane_ctl_t           lane_ctl;
  cal_ctl_t            cal_ctl;

  assign in_ch.ready = state_r == ST_IDLE;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_W'(3277);
      thresh_r <= THR_W'(1280);
      one_g_r  <= ONE_G_W'(512);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALPHA:  alpha_r  <= cfg_data[ALPHA_W-1:0];
        CFG_THRESH: thresh_r <= cfg_data[THR_W-1:0];
        CFG_ONE_G:  one_g_r  <= cfg_data[ONE_G_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_ch.mode;
      raw_r[0] <= in_ch.accel1_x;
      raw_r[1] <= in_ch.accel1_y;
      raw_r[2] <= in_ch.accel1_z;
      raw_r[3] <= in_ch.accel2_x;
      raw_r[4] <= in_ch.accel2_y;
      raw_r[5] <= in_ch.accel2_z;
    end
    if (state_r == ST_VSUB) begin
      for (int i = 0; i < 6; i++) begin
        v_r[i] <= V_W'(raw_r[i]) - V_W'(offs[i]);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = in_ch.mode ? ST_CAL : ST_VSUB;
      ST_CAL:  state_nxt = hit ? ST_DIV : ST_DONE;
      ST_DIV:  state_nxt = ST_OFFS;
      ST_OFFS: state_nxt = ST_DONE;
      ST_VSUB: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_ROT;
      ST_ROT:  if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FILT;
      ST_FILT: state_nxt = ST_DONE;
      ST_DONE: if (free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    lane_ctl      = '0;
    cal_ctl       = '0;
    lane_ctl.step = step_r[3:0];
    load          = 1'b0;
    done_nxt      = done_r;
    step_nxt      = (state_nxt != state_r) ? '0 : step_r + STEP_W'(1);
    case (state_r)
      ST_IDLE: done_nxt      = 1'b0;
      ST_CAL:  cal_ctl.acc   = 1'b1;
      ST_DIV:  cal_ctl.div   = 1'b1;
      ST_OFFS: begin
        cal_ctl.offs = 1'b1;
        done_nxt     = 1'b1;
      end
      ST_SQR:  lane_ctl.sqr  = 1'b1;
      ST_SUM:  lane_ctl.sum  = 1'b1;
      ST_ROOT: lane_ctl.root = 1'b1;
      ST_INIT: lane_ctl.init = 1'b1;
      ST_ROT:  lane_ctl.rot  = 1'b1;
      ST_RND:  lane_ctl.rnd  = 1'b1;
      ST_MUL:  lane_ctl.mul  = 1'b1;
      ST_FILT: lane_ctl.filt = 1'b1;
      ST_DONE: load          = free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  dat_cal u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cal_ctl),
    .raw   (raw_r),
    .one_g (one_g_r),
    .hit   (hit),
    .offs  (offs)
  );

  // sensor two reports roll and pitch swapped
  dat_lane u_lane_r1 (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .num (v_r[1]), .a (v_r[0]), .b (v_r[2]), .alpha (alpha_r), .filt (ang[0])
  );
  dat_lane u_lane_p1 (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .num (-v_r[0]), .a (v_r[1]), .b (v_r[2]), .alpha (alpha_r), .filt (ang[1])
  );
  dat_lane u_lane_r2 (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .num (-v_r[3]), .a (v_r[4]), .b (v_r[5]), .alpha (alpha_r), .filt (ang[2])
  );
  dat_lane u_lane_p2 (
    .clk (clk), .rst_n (rst_n), .ctl (lane_ctl),
    .num (v_r[4]), .a (v_r[3]), .b (v_r[5]), .alpha (alpha_r), .filt (ang[3])
  );

  dat_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .ang      (ang),
    .thresh   (thresh_r),
    .cal_done (done_r),
    .free     (free),
    .out_ch   (out_ch)
  );

  a_cal_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode) |=> (state_r == ST_CAL))
    else $error("calibration item did not enter accumulation");

  a_rot_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT && step_r == STEP_W'(CORDIC_STEPS - 1)) |=> (state_r == ST_RND))
    else $error("cordic did not finish after its last step");

  a_offs_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OFFS) |=> (done_r && state_r == ST_DONE))
    else $error("offset update not flagged");

  a_measure_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILT) |-> !done_r)
    else $error("measure item flagged as calibration end");

endmodule
